@@ src/delta_frame_buffer_updater_assert.svh @@
// Assertion macros shared by the checker of the frame buffer updater.
`ifndef DELTA_FRAME_BUFFER_UPDATER_ASSERT_SVH
`define DELTA_FRAME_BUFFER_UPDATER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DFBU_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DFBU_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/dfbu_pkg.sv @@
// Shared constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps
package dfbu_pkg;

  localparam int MAX_PIXELS    = 65536;
  localparam int PIXEL_BITS    = 16;
  localparam int MAX_DIMENSION = 1024;

  localparam int ADDR_W    = $clog2(MAX_PIXELS);
  localparam int TOTAL_W   = ADDR_W + 1;
  localparam int REM_W     = 17;
  localparam int DIM_W     = 11;
  localparam int COORD_W   = 10;
  localparam int CNT_W     = 16;
  localparam int COLOR_W   = 16;
  localparam int MODE_W    = 3;
  localparam int STATUS_W  = 3;
  localparam int IN_DATA_W = 96;
  localparam int OUT_DATA_W = 32;

  localparam logic [MODE_W-1:0] MODE_RUN   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PIXEL = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FILL  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RECT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

  localparam logic [STATUS_W-1:0] STS_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] STS_RUN_BOUNDS  = 3'd1;
  localparam logic [STATUS_W-1:0] STS_FILL_BOUNDS = 3'd2;
  localparam logic [STATUS_W-1:0] STS_RECT_BOUNDS = 3'd3;
  localparam logic [STATUS_W-1:0] STS_STRAY       = 3'd4;
  localparam logic [STATUS_W-1:0] STS_INCOMPLETE  = 3'd5;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic capture;
    logic exec;
    logic rect_commit;
    logic fill_step;
    logic clear_step;
    logic finish;
  } dfbu_cmd_t;

  typedef struct packed {
    logic go_fill;
    logic go_rect;
    logic fill_last;
    logic clear_last;
    logic out_free;
  } dfbu_sts_t;

  // Clamp a dimension register to the largest supported size.
  function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] lim;
    lim = DIM_W'(MAX_DIMENSION);
    return (d > lim) ? lim : d;
  endfunction

endpackage

@@ src/dfbu_ctrl.sv @@
// Controller state machine: sequences clear, execute, rectangle, fill and finish.
`timescale 1ns / 1ps
module dfbu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  dfbu_pkg::dfbu_sts_t sts,
  output dfbu_pkg::dfbu_cmd_t cmd
);
  import dfbu_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_EXEC   = 6'b000100,
    ST_RECT   = 6'b001000,
    ST_FILL   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.go_fill) begin
          state_next = ST_FILL;
        end else if (sts.go_rect) begin
          state_next = ST_RECT;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_RECT: begin
        cmd.rect_commit = 1'b1;
        state_next      = ST_FINISH;
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

@@ src/dfbu_datapath.sv @@
// Datapath: config registers, item registers, run/rectangle state, frame store, output stage.
`timescale 1ns / 1ps
module dfbu_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [dfbu_pkg::DIM_W-1:0]            cfg_data,
  input  logic [dfbu_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  input  logic [dfbu_pkg::MODE_W-1:0]           s_axis_tuser,
  input  logic                                  s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [dfbu_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  output logic [dfbu_pkg::STATUS_W-1:0]         m_axis_tuser,
  input  dfbu_pkg::dfbu_cmd_t                   cmd,
  output dfbu_pkg::dfbu_sts_t                   sts
);
  import dfbu_pkg::*;

  // configuration
  logic [DIM_W-1:0]   image_width, image_height;
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [2*DIM_W-1:0] area;
  logic [TOTAL_W-1:0] total;

  // captured item
  logic [MODE_W-1:0]  it_mode;
  logic [CNT_W-1:0]   it_idx, it_cnt;
  logic [COLOR_W-1:0] it_color;
  logic [COORD_W-1:0] it_rx, it_ry;
  logic [DIM_W-1:0]   it_rw, it_rh;
  logic               it_fend;

  // run and rectangle state
  logic [ADDR_W-1:0]  write_address;
  logic [REM_W-1:0]   remaining_pixels;
  logic               in_rectangle;
  logic [DIM_W-1:0]   rect_column;
  logic [DIM_W-1:0]   rect_width_held;
  logic [ADDR_W-1:0]  row_base_address;

  logic [STATUS_W-1:0] status_r;
  logic [ADDR_W-1:0]   fill_addr;
  logic [CNT_W-1:0]    fill_left;
  logic [ADDR_W-1:0]   clear_addr;

  // rectangle products, registered in the execute cycle
  logic [COORD_W+DIM_W-1:0] prod_a;
  logic [2*DIM_W-1:0]       prod_b;
  logic [DIM_W+DIM_W:0]     prod_c;

  // frame store
  logic [PIXEL_BITS-1:0] frame_store [MAX_PIXELS];
  logic [PIXEL_BITS-1:0] rd_data;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [PIXEL_BITS-1:0] mem_wdata;

  // output stage
  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [COLOR_W-1:0]    out_rd;
  logic [CNT_W-1:0]      out_owed;

  logic                owed, is_hdr, in_bounds, pix_write;
  logic [TOTAL_W-1:0]  sum_ic;
  logic [DIM_W-1:0]    col_inc;
  logic                row_wrap;
  logic [ADDR_W-1:0]   row_next;
  logic [DIM_W:0]      ry_last;
  logic [DIM_W:0]      x_end, y_end;
  logic                rect_bad;
  logic [2*DIM_W+1:0]  last_end;
  logic [STATUS_W-1:0] fin_status;
  logic [CNT_W-1:0]    fin_owed;
  logic [COLOR_W-1:0]  fin_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(256);
      image_height <= DIM_W'(256);
    end else if (cfg_we) begin
      if (cfg_index == CFG_WIDTH) begin
        image_width <= cfg_data;
      end else begin
        image_height <= cfg_data;
      end
    end
  end

  assign w_eff = dim_eff(image_width);
  assign h_eff = dim_eff(image_height);
  assign area  = w_eff * h_eff;

  always_ff @(posedge clk) begin
    total <= (area > (2*DIM_W)'(MAX_PIXELS)) ? TOTAL_W'(MAX_PIXELS) : area[TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_mode  <= s_axis_tuser;
      it_idx   <= s_axis_tdata[15:0];
      it_cnt   <= s_axis_tdata[31:16];
      it_color <= s_axis_tdata[47:32];
      it_rx    <= s_axis_tdata[57:48];
      it_ry    <= s_axis_tdata[67:58];
      it_rw    <= s_axis_tdata[78:68];
      it_rh    <= s_axis_tdata[89:79];
      it_fend  <= s_axis_tlast;
    end
  end

  assign owed      = (remaining_pixels != '0);
  assign is_hdr    = (it_mode == MODE_RUN) || (it_mode == MODE_FILL) || (it_mode == MODE_RECT);
  assign sum_ic    = {1'b0, it_idx} + {1'b0, it_cnt};
  assign in_bounds = (sum_ic <= total);
  assign pix_write = cmd.exec && (it_mode == MODE_PIXEL) && owed;

  assign col_inc  = rect_column + DIM_W'(1);
  assign row_wrap = (col_inc >= rect_width_held);
  assign row_next = row_base_address + ADDR_W'(w_eff);

  assign ry_last = (DIM_W+1)'(it_ry) + (DIM_W+1)'(it_rh) - (DIM_W+1)'(1);
  assign x_end   = (DIM_W+1)'(it_rx) + (DIM_W+1)'(it_rw);
  assign y_end   = (DIM_W+1)'(it_ry) + (DIM_W+1)'(it_rh);
  assign last_end = (2*DIM_W+2)'(prod_c) + (2*DIM_W+2)'(it_rx) + (2*DIM_W+2)'(it_rw);
  assign rect_bad = (x_end > (DIM_W+1)'(w_eff)) || (y_end > (DIM_W+1)'(h_eff)) ||
                    ((it_rw != '0) && (it_rh != '0) &&
                     (last_end > (2*DIM_W+2)'(total)));

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      prod_a <= it_ry * w_eff;
      prod_b <= it_rw * it_rh;
      prod_c <= ry_last * w_eff;
    end
  end

  // run and rectangle bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      write_address    <= '0;
      remaining_pixels <= '0;
      in_rectangle     <= 1'b0;
      rect_column      <= '0;
      rect_width_held  <= '0;
      row_base_address <= '0;
    end else if (cmd.exec) begin
      if (is_hdr && owed) begin
        // abandon the open run, drop the header
        remaining_pixels <= '0;
        in_rectangle     <= 1'b0;
      end else if (it_mode == MODE_RUN) begin
        if (in_bounds && (it_cnt != '0)) begin
          write_address    <= it_idx;
          remaining_pixels <= REM_W'(it_cnt);
          in_rectangle     <= 1'b0;
        end
      end else if (pix_write) begin
        remaining_pixels <= remaining_pixels - REM_W'(1);
        if (in_rectangle) begin
          if (row_wrap) begin
            rect_column      <= '0;
            row_base_address <= row_next;
            write_address    <= row_next;
          end else begin
            rect_column   <= col_inc;
            write_address <= write_address + ADDR_W'(1);
          end
        end else begin
          write_address <= write_address + ADDR_W'(1);
        end
        if (remaining_pixels == REM_W'(1)) in_rectangle <= 1'b0;
      end
    end else if (cmd.rect_commit) begin
      if (!rect_bad && (it_rw != '0) && (it_rh != '0)) begin
        row_base_address <= prod_a[ADDR_W-1:0] + ADDR_W'(it_rx);
        write_address    <= prod_a[ADDR_W-1:0] + ADDR_W'(it_rx);
        rect_column      <= '0;
        rect_width_held  <= it_rw;
        remaining_pixels <= prod_b[REM_W-1:0];
        in_rectangle     <= 1'b1;
      end
    end else if (cmd.finish && it_fend) begin
      remaining_pixels <= '0;
      in_rectangle     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (is_hdr && owed) begin
        status_r <= STS_INCOMPLETE;
      end else begin
        case (it_mode)
          MODE_RUN:   status_r <= in_bounds ? STS_OK : STS_RUN_BOUNDS;
          MODE_PIXEL: status_r <= owed ? STS_OK : STS_STRAY;
          MODE_FILL:  status_r <= in_bounds ? STS_OK : STS_FILL_BOUNDS;
          default:    status_r <= STS_OK;
        endcase
      end
    end else if (cmd.rect_commit && rect_bad) begin
      status_r <= STS_RECT_BOUNDS;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      fill_addr <= it_idx;
      fill_left <= it_cnt;
    end else if (cmd.fill_step) begin
      fill_addr <= fill_addr + ADDR_W'(1);
      fill_left <= fill_left - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_step) begin
      clear_addr <= clear_addr + ADDR_W'(1);
    end
  end

  // one write port shared by clearing, fills and pixel items
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = write_address;
    mem_wdata = PIXEL_BITS'(it_color);
    if (cmd.clear_step) begin
      mem_we    = 1'b1;
      mem_waddr = clear_addr;
      mem_wdata = '0;
    end else if (cmd.fill_step) begin
      mem_we    = 1'b1;
      mem_waddr = fill_addr;
    end else if (pix_write) begin
      mem_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) frame_store[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && (it_mode == MODE_READ)) rd_data <= frame_store[it_idx[ADDR_W-1:0]];
  end

  // apply the frame end rule on the way out
  assign fin_status = (it_fend && owed && (status_r == STS_OK)) ? STS_INCOMPLETE : status_r;
  assign fin_owed   = it_fend ? '0 :
                      (remaining_pixels[REM_W-1] ? '1 : remaining_pixels[CNT_W-1:0]);
  assign fin_rd     = (it_mode == MODE_READ) ? COLOR_W'(rd_data) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status <= fin_status;
      out_rd     <= fin_rd;
      out_owed   <= fin_owed;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_owed, out_rd};
  assign m_axis_tuser  = out_status;

  assign sts.go_fill    = (it_mode == MODE_FILL) && !owed && in_bounds && (it_cnt != '0);
  assign sts.go_rect    = (it_mode == MODE_RECT) && !owed;
  assign sts.fill_last  = (fill_left == CNT_W'(1));
  assign sts.clear_last = (clear_addr == ADDR_W'(MAX_PIXELS - 1));
  assign sts.out_free   = !out_valid || m_axis_tready;

endmodule

@@ src/delta_frame_buffer_updater.sv @@
// Top level of the delta frame buffer updater.
//
// Input stream: one frame record item per transfer; tuser carries the mode, tlast
// the frame end flag, tdata the index, count, color and rectangle fields.
// Output stream: one result per item; tuser carries the status, tdata the read
// pixel and the pixels still owed (saturated at 65535).
// Configuration: write image_width (index 0) or image_height (index 1) with cfg_we.
// After reset the frame store is cleared one entry per cycle with tready low;
// configuration writes are taken during that time.
// Each item passes idle, execute and finish steps; a rectangle header adds a
// rectangle step (its products are registered before the bounds compare), and
// a fill adds a fill step, which writes one pixel per cycle through the single
// write port of the store.
// The result sits in an output register; the next item is taken while it waits.
// If the receiver stalls, the following item completes its work and holds in the
// finish step until the output register frees up.
`timescale 1ns / 1ps
module delta_frame_buffer_updater (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [dfbu_pkg::DIM_W-1:0]          cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: pixel_index[15:0], pixel_count[31:16], color[47:32], rect_x[57:48],
  //        rect_y[67:58], rect_w[78:68], rect_h[89:79], zero pad[95:90]
  input  logic [dfbu_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: mode[2:0]
  input  logic [dfbu_pkg::MODE_W-1:0]         s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: read_pixel[15:0], pixels_owed[31:16]
  output logic [dfbu_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // tuser: status[2:0]
  output logic [dfbu_pkg::STATUS_W-1:0]       m_axis_tuser
);
  import dfbu_pkg::*;

  dfbu_cmd_t cmd;
  dfbu_sts_t sts;

  dfbu_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  dfbu_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

@@ src/dfbu_checker.sv @@
// Port-level checker for the delta frame buffer updater, bound to the top level.
`timescale 1ns / 1ps
`include "delta_frame_buffer_updater_assert.svh"
module dfbu_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [dfbu_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input logic [dfbu_pkg::STATUS_W-1:0]       m_axis_tuser
);
  import dfbu_pkg::*;

  logic out_stall;
  logic in_quiet;
  logic status_ok;
  logic out_stray;
  logic out_incomplete;
  logic owed_zero;

  assign out_stall      = m_axis_tvalid && !m_axis_tready;
  assign in_quiet       = !s_axis_tready && !m_axis_tvalid;
  assign status_ok      = (m_axis_tuser <= STS_INCOMPLETE);
  assign out_stray      = m_axis_tvalid && (m_axis_tuser == STS_STRAY);
  assign out_incomplete = m_axis_tvalid && (m_axis_tuser == STS_INCOMPLETE);
  assign owed_zero      = (m_axis_tdata[31:16] == '0);

  // a stalled result stays offered
  `DFBU_ASSERT_NXT(a_out_hold, clk, rst, out_stall, m_axis_tvalid, "result dropped while stalled")

  // the store is being cleared right after reset: no item, no result
  `DFBU_ASSERT_IMP(a_clear_after_reset, clk, rst, $past(rst), in_quiet, "busy while clearing")

  `DFBU_ASSERT_IMP(a_status_range, clk, rst, m_axis_tvalid, status_ok, "status code out of range")

  // a stray pixel leaves nothing owed and reads nothing
  `DFBU_ASSERT_IMP(a_stray_empty, clk, rst, out_stray, m_axis_tdata == '0, "stray result not empty")

  // incomplete data always closes the open run
  `DFBU_ASSERT_IMP(a_incomplete_closes, clk, rst, out_incomplete, owed_zero, "owed after incomplete")

endmodule

bind delta_frame_buffer_updater dfbu_checker u_dfbu_checker (.*);
